### hw/rtl/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is held.
`define STT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Clocked property, checked during reset as well.
`define STT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

### hw/rtl/stt_pkg.sv
package stt_pkg;

    // stream payload widths
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 88;
    localparam int APB_ADDR_W = 3;

    // event kinds (tuser)
    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_SYNC    = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_HARD_RESYNC = 1'b0;
    localparam logic REG_MAX_STEP    = 1'b1;

    localparam logic [15:0] HARD_RESYNC_RESET = 16'd1000;
    localparam logic [15:0] MAX_STEP_RESET    = 16'd50;
    localparam logic [7:0]  BRIGHT_RESET      = 8'd128;

    // master time unwrap
    localparam logic [31:0] HIGH8_MASK = 32'hFF00_0000;
    localparam logic [31:0] HALF_WRAP  = 32'h0080_0000;
    localparam logic [31:0] FULL_WRAP  = 32'h0100_0000;

    // flag bit positions
    localparam int FL_POWER   = 0;
    localparam int FL_HASBRI  = 1;
    localparam int FL_REAPPLY = 2;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [23:0] master_ts;
        logic [7:0]  sync_brightness;
        logic [7:0]  ctrl_preset;
        logic [7:0]  ctrl_brightness;
        logic        ctrl_power_on;
        logic        ctrl_has_bri;
        logic        ctrl_arm;
        logic        ctrl_force_reapply;
        logic [7:0]  active_preset;
    } item_t;

    typedef struct packed {
        logic [31:0] timebase;
        logic [31:0] tb_error;
        logic        hard_resync;
        logic        apply_preset;
        logic [7:0]  preset_id;
        logic [7:0]  brightness;
        logic        brightness_update;
    } result_t;

    typedef struct packed {
        logic        have_sync;
        logic [31:0] master_epoch;
        logic [31:0] last_sync_local;
        logic [31:0] timebase;
        logic [31:0] last_error;
        logic        pending_armed;
        logic [7:0]  pending_preset;
        logic [7:0]  pending_bri;
        logic [2:0]  pending_flags;
        logic        have_control;
        logic [1:0]  current_flags;
        logic [7:0]  bright;
    } state_t;

    // tracker state after reset
    localparam state_t STATE_RESET = '{
        have_sync:       1'b0,
        master_epoch:    32'd0,
        last_sync_local: 32'd0,
        timebase:        32'd0,
        last_error:      32'd0,
        pending_armed:   1'b0,
        pending_preset:  8'd0,
        pending_bri:     8'd0,
        pending_flags:   3'd0,
        have_control:    1'b0,
        current_flags:   2'd0,
        bright:          BRIGHT_RESET
    };

    typedef struct packed {
        logic [15:0] hard_resync_ms;
        logic [15:0] max_step_ms;
    } cfg_t;

endpackage

### hw/rtl/stt_core.sv
// Event update: next tracker state and the result of one event.
module stt_core (
    input  stt_pkg::item_t   item,
    input  stt_pkg::state_t  state,
    input  stt_pkg::cfg_t    cfg,
    output stt_pkg::state_t  state_next,
    output stt_pkg::result_t result
);

    logic [31:0] pred;
    logic [31:0] cand;
    logic [31:0] cand_adj;
    logic [31:0] mabs;
    logic [31:0] desired;
    logic [31:0] err;
    logic [31:0] aerr;
    logic [31:0] hard_lim;
    logic [31:0] step_lim;
    logic [31:0] step;
    logic        hard;

    // unwrap the 24-bit stamp to the master time nearest the prediction once synced
    always_comb
    begin
        pred     = state.master_epoch + (item.now_ms - state.last_sync_local);
        cand     = (pred & stt_pkg::HIGH8_MASK) | {8'd0, item.master_ts};
        cand_adj = cand;
        if ((cand + stt_pkg::HALF_WRAP) < pred)
        begin
            cand_adj = cand + stt_pkg::FULL_WRAP;
        end
        else if (cand > (pred + stt_pkg::HALF_WRAP))
        begin
            cand_adj = cand - stt_pkg::FULL_WRAP;
        end
        mabs = state.have_sync ? cand_adj : {8'd0, item.master_ts};
    end

    // error, jump decision and clamped slew step
    always_comb
    begin
        desired  = mabs - item.now_ms;
        err      = desired - state.timebase;
        aerr     = err[31] ? (32'd0 - err) : err;
        hard_lim = {16'd0, cfg.hard_resync_ms};
        step_lim = {16'd0, cfg.max_step_ms};
        hard     = state.pending_armed || (aerr > hard_lim);
        step     = err;
        if (!err[31])
        begin
            if (err > step_lim)
            begin
                step = step_lim;
            end
        end
        else
        begin
            if (aerr > step_lim)
            begin
                step = 32'd0 - step_lim;
            end
        end
    end

    always_comb
    begin
        state_next               = state;
        result.hard_resync       = 1'b0;
        result.apply_preset      = 1'b0;
        result.preset_id         = 8'd0;
        result.brightness_update = 1'b0;

        case (item.operation)
            stt_pkg::OP_CONTROL:
            begin
                state_next.pending_preset = item.ctrl_preset;
                state_next.pending_bri    = item.ctrl_brightness;
                state_next.pending_flags  = {item.ctrl_force_reapply, item.ctrl_has_bri,
                                             item.ctrl_power_on};
                state_next.have_control   = 1'b1;
                state_next.current_flags  = {item.ctrl_has_bri, item.ctrl_power_on};
                state_next.pending_armed  = item.ctrl_arm;
                if (!item.ctrl_arm)
                begin
                    result.apply_preset      = 1'b1;
                    result.preset_id         = item.ctrl_preset;
                    result.brightness_update = 1'b1;
                    if (!item.ctrl_power_on)
                    begin
                        state_next.bright = 8'd0;
                    end
                    else if (item.ctrl_has_bri)
                    begin
                        state_next.bright = item.ctrl_brightness;
                    end
                end
            end
            default:
            begin
                state_next.have_sync       = 1'b1;
                state_next.master_epoch    = mabs;
                state_next.last_sync_local = item.now_ms;
                state_next.last_error      = err;
                state_next.timebase        = hard ? desired : (state.timebase + step);
                result.hard_resync         = hard;

                if (state.pending_armed)
                begin
                    if (state.pending_flags[stt_pkg::FL_REAPPLY] ||
                        (item.active_preset != state.pending_preset))
                    begin
                        result.apply_preset = 1'b1;
                        result.preset_id    = state.pending_preset;
                    end
                    if (!state.pending_flags[stt_pkg::FL_POWER])
                    begin
                        state_next.bright = 8'd0;
                    end
                    else if (state.pending_flags[stt_pkg::FL_HASBRI])
                    begin
                        state_next.bright = state.pending_bri;
                    end
                    else
                    begin
                        state_next.bright = item.sync_brightness;
                    end
                    result.brightness_update = 1'b1;
                    state_next.current_flags = state.pending_flags[1:0];
                    state_next.pending_armed = 1'b0;
                end
                else if (state.have_control && !state.current_flags[stt_pkg::FL_HASBRI])
                begin
                    // live brightness tracking
                    if (state.current_flags[stt_pkg::FL_POWER])
                    begin
                        state_next.bright = item.sync_brightness;
                    end
                    else
                    begin
                        state_next.bright = 8'd0;
                    end
                    result.brightness_update = (state_next.bright != state.bright);
                end
            end
        endcase

        result.timebase   = state_next.timebase;
        result.tb_error   = state_next.last_error;
        result.brightness = state_next.bright;
    end

endmodule

### hw/rtl/sync_timebase_tracker.sv
// Sync timebase tracker. Takes one event transaction per cycle on the slave
// stream (tuser 0 = control message, 1 = sync pulse) while no result is
// stalled, and returns exactly one result transaction per event, in order.
// An event sits in an input register, and the whole update (timestamp
// unwrap, error, jump or clamped slew, preset and brightness decision) is
// combinational from that register into the result register, so throughput
// is one event per clock while the output is not stalled; m_tvalid rises
// once the event has passed from the input register to the result register.
// The rate is set by the single state-update path through the unwrap adders
// and the error/clamp compare; each event sees the state left by the one
// before it. Two APB registers: hard_resync_ms at 0x0 and max_step_ms at
// 0x4 (low 16 bits); write them only while no event is in flight.
module sync_timebase_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], master_ts[55:32], sync_brightness[63:56], ctrl_preset[71:64],
    // ctrl_brightness[79:72], ctrl_power_on[80], ctrl_has_bri[81], ctrl_arm[82],
    // ctrl_force_reapply[83], active_preset[91:84], zero[95:92]
    input  logic [stt_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                              s_tuser,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // timebase[31:0], tb_error[63:32], hard_resync[64], apply_preset[65],
    // preset_id[73:66], brightness[81:74], brightness_update[82], zero[87:83]
    output logic [stt_pkg::M_TDATA_W-1:0]     m_tdata,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    stt_pkg::cfg_t    cfg_reg;
    stt_pkg::state_t  state_reg;
    stt_pkg::state_t  state_next;
    stt_pkg::item_t   in_item;
    stt_pkg::item_t   in_reg;
    stt_pkg::result_t res_next;
    stt_pkg::result_t res_reg;
    logic             in_v_reg;
    logic             out_v_reg;
    logic             s_fire;
    logic             exec;
    logic             cfg_wr;

    // ---------------------------------------------------------------
    // APB: zero wait states, register chosen by paddr[2]
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hard_resync_ms <= stt_pkg::HARD_RESYNC_RESET;
            cfg_reg.max_step_ms    <= stt_pkg::MAX_STEP_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                stt_pkg::REG_HARD_RESYNC: cfg_reg.hard_resync_ms <= pwdata[15:0];
                stt_pkg::REG_MAX_STEP:    cfg_reg.max_step_ms    <= pwdata[15:0];
                default:                  cfg_reg.max_step_ms    <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            stt_pkg::REG_HARD_RESYNC: prdata = {16'd0, cfg_reg.hard_resync_ms};
            stt_pkg::REG_MAX_STEP:    prdata = {16'd0, cfg_reg.max_step_ms};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Two-register pipeline: input register -> update -> result register.
    // The update runs whenever an event is held and the result register is free or draining.
    // ---------------------------------------------------------------
    assign exec     = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || exec;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_item.operation          = s_tuser;
        in_item.now_ms             = s_tdata[31:0];
        in_item.master_ts          = s_tdata[55:32];
        in_item.sync_brightness    = s_tdata[63:56];
        in_item.ctrl_preset        = s_tdata[71:64];
        in_item.ctrl_brightness    = s_tdata[79:72];
        in_item.ctrl_power_on      = s_tdata[80];
        in_item.ctrl_has_bri       = s_tdata[81];
        in_item.ctrl_arm           = s_tdata[82];
        in_item.ctrl_force_reapply = s_tdata[83];
        in_item.active_preset      = s_tdata[91:84];
    end

    stt_core u_core (
        .item       (in_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= s_fire || (in_v_reg && !exec);
            out_v_reg <= exec || (out_v_reg && !m_tready);
        end
    end

    // tracker state, committed as each event executes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stt_pkg::STATE_RESET;
        end
        else if (exec)
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg <= in_item;
        end
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0,
                       res_reg.brightness_update,
                       res_reg.brightness,
                       res_reg.preset_id,
                       res_reg.apply_preset,
                       res_reg.hard_resync,
                       res_reg.tb_error,
                       res_reg.timebase};

endmodule

### hw/rtl/stt_checker.sv
`include "assert_macros.svh"

module stt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [stt_pkg::APB_ADDR_W-1:0] paddr,
    input logic [31:0]                    pwdata,
    input logic [31:0]                    prdata,
    input logic                           pready
);

    logic cfg_wr_hard;

    assign cfg_wr_hard = psel && penable && pwrite && pready && !paddr[2];

    // no result is pending once a reset edge has been seen
    `STT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid)

    // a stalled result holds its payload
    `STT_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // input only back-pressures when a result is stalled
    `STT_ASSERT(a_in_bp, clk, rst_n, !s_tready |-> m_tvalid && !m_tready)

    // no preset id without an apply request
    `STT_ASSERT(a_pid_zero, clk, rst_n, m_tvalid && !m_tdata[65] |-> m_tdata[73:66] == 8'd0)

    // hard-resync register reads back what was written
    `STT_ASSERT(a_cfg_rb, clk, rst_n, cfg_wr_hard |=> paddr[2] || prdata == 32'($past(pwdata[15:0])))

endmodule

bind sync_timebase_tracker stt_checker u_stt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);
